>>> rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 2;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLR = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the item and load the result register
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output spq_pkg::t_cmd    o_cmd
);
    import spq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.exec || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/spq_datapath.sv
`default_nettype none

module spq_datapath #(
    parameter int DEPTH = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire spq_pkg::t_cmd                       i_cmd,
    input  wire logic        [spq_pkg::ACT_W-1:0]    i_action,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   i_value,
    input  wire logic        [spq_pkg::PRIO_W-1:0]   i_priority_req,
    output logic             [spq_pkg::STAT_W-1:0]   o_status,
    output logic signed      [spq_pkg::DATA_W-1:0]   o_removed_value,
    output logic signed      [spq_pkg::DATA_W-1:0]   o_head_value,
    output logic             [spq_pkg::TOTAL_W-1:0]  o_entry_total,
    output logic                                     o_is_empty,
    output logic                                     o_is_full
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // captured item
    logic [ACT_W-1:0]         r_act;
    logic signed [DATA_W-1:0] r_val;
    logic [PRIO_W-1:0]        r_pri;

    // sorted storage, head at slot 0
    logic signed [DATA_W-1:0] r_data [DEPTH];
    logic [PRIO_W-1:0]        r_prio [DEPTH];
    logic signed [DATA_W-1:0] n_data [DEPTH];
    logic [PRIO_W-1:0]        n_prio [DEPTH];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;

    // shifted-back copies for insertion
    logic signed [DATA_W-1:0] sh_data [DEPTH];
    logic [PRIO_W-1:0]        sh_prio [DEPTH];

    logic [DEPTH-1:0]         keep;
    logic [DEPTH-1:0]         prev_keep;
    logic                     is_full_now;

    logic [STAT_W-1:0]        n_status;
    logic signed [DATA_W-1:0] n_removed;
    logic signed [DATA_W-1:0] n_head;

    // result register
    logic [STAT_W-1:0]        r_status;
    logic signed [DATA_W-1:0] r_removed;
    logic signed [DATA_W-1:0] r_head;
    logic [TOTAL_W-1:0]       r_total;
    logic                     r_empty;
    logic                     r_full;

    assign is_full_now = (r_count == CW'(DEPTH));

    // an entry stays in place when it is live and ranks equal or higher
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            keep[i] = (CW'(i) < r_count) && (r_prio[i] >= r_pri);
        end
    end

    assign prev_keep = {keep[DEPTH-2:0], 1'b1};

    always_comb begin
        sh_data[0] = r_data[0];
        sh_prio[0] = r_prio[0];
        for (int i = 1; i < DEPTH; i++) begin
            sh_data[i] = r_data[i-1];
            sh_prio[i] = r_prio[i-1];
        end
    end

    always_comb begin
        n_data    = r_data;
        n_prio    = r_prio;
        n_count   = r_count;
        n_status  = ST_DONE;
        n_removed = '0;
        case (r_act)
            ACT_ENQ: begin
                if (is_full_now) begin
                    n_status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (keep[i]) begin
                            n_data[i] = r_data[i];
                            n_prio[i] = r_prio[i];
                        end else if (prev_keep[i]) begin
                            n_data[i] = r_val;
                            n_prio[i] = r_pri;
                        end else begin
                            n_data[i] = sh_data[i];
                            n_prio[i] = sh_prio[i];
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            ACT_DEQ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed = r_data[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_data[i] = r_data[i+1];
                        n_prio[i] = r_prio[i+1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            ACT_CLR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign n_head = (n_count != '0) ? n_data[0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_val <= i_value;
            r_pri <= i_priority_req;
        end
        if (i_cmd.exec) begin
            r_data    <= n_data;
            r_prio    <= n_prio;
            r_status  <= n_status;
            r_removed <= n_removed;
            r_head    <= n_head;
            r_total   <= TOTAL_W'(n_count);
            r_empty   <= (n_count == '0);
            r_full    <= (n_count == CW'(DEPTH));
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_head_value    = r_head;
    assign o_entry_total   = r_total;
    assign o_is_empty      = r_empty;
    assign o_is_full       = r_full;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue_core.sv
// sorted priority queue, up to DEPTH entries kept in descending priority order
// input channel: i_in_valid / o_in_stall carry one item (i_action,
//   i_value, i_priority_req); action is enqueue, dequeue or clear
// output channel: o_out_valid / i_out_stall carry one result per item
//   (status, removed value, head value, count, empty and full flags)
// enqueue goes behind all entries of equal or higher priority, so equal
//   priorities leave first-in first-out
// each item passes a capture step into the item register and an apply step
//   that acts across all slots with a parallel compare and shift and loads the
//   result register; a new item is not taken until the last one is applied
// o_in_stall is high while an item is being applied
// if the receiver stalls, the result holds and a following item waits in
//   the apply step until the result register is taken
// reset: queue count goes to zero, no result pending; slot contents are
//   left as they are and never read before written
`default_nettype none

module sorted_priority_queue_core #(
    parameter int DEPTH = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic        [spq_pkg::ACT_W-1:0]    i_action,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   i_value,
    input  wire logic        [spq_pkg::PRIO_W-1:0]   i_priority_req,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic             [spq_pkg::STAT_W-1:0]   o_status,
    output logic signed      [spq_pkg::DATA_W-1:0]   o_removed_value,
    output logic signed      [spq_pkg::DATA_W-1:0]   o_head_value,
    output logic             [spq_pkg::TOTAL_W-1:0]  o_entry_total,
    output logic                                     o_is_empty,
    output logic                                     o_is_full
);
    import spq_pkg::*;

    // command from controller to datapath
    t_cmd cmd;

    // controller: capture step, apply step, result valid
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // datapath: slot registers, insert position compare, shift, result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_priority_req  (i_priority_req),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_entry_total   (o_entry_total),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

`ifndef SYNTHESIS
    // a queue of one or more slots is never empty and full at once
    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_empty && o_is_full))
        else $error("result reports empty and full together");

    // a rejected dequeue only happens on an empty queue and returns zero
    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |->
            (o_is_empty && (o_removed_value == '0)))
        else $error("empty reject with live queue or nonzero value");

    // a rejected enqueue only happens on a full queue
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> o_is_full)
        else $error("full reject while queue not full");

    // an accepted item blocks the input for the apply step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled during apply step");
`endif

endmodule

`default_nettype wire

>>> bench/sorted_priority_queue_core_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_core_test;

    import spq_pkg::*;

    localparam int QDEPTH         = 8;
    localparam int IDLE_PCT       = 20;    // chance in a hundred that a side idles this cycle
    localparam int RANDOM_ITEMS   = 650;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with nothing accepted on either side

    // action code the block leaves unused: must act as a no-op
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    // priority codes; the top code ranks above high
    localparam logic [PRIO_W-1:0] PRI_LOW  = 2'd0;
    localparam logic [PRIO_W-1:0] PRI_MED  = 2'd1;
    localparam logic [PRIO_W-1:0] PRI_HIGH = 2'd2;
    localparam logic [PRIO_W-1:0] PRI_TOP  = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // what one result item reports
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] head;
        logic [TOTAL_W-1:0]       total;
        logic                     empty;
        logic                     full;
    } queue_report_t;

    // one row of the directed table; typed rows carry their answer
    typedef struct {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
        logic [PRIO_W-1:0]        prio;
        bit                       typed;
        queue_report_t            want;
    } stim_row_t;

    // reports that can be read straight off the spec
    localparam queue_report_t REP_EMPTY_REJECT = '{ST_EMPTY, 32'sd0, 32'sd0, 4'd0, 1'b1, 1'b0};
    localparam queue_report_t REP_CLEARED      = '{ST_DONE,  32'sd0, 32'sd0, 4'd0, 1'b1, 1'b0};

    logic                        i_clk;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic [ACT_W-1:0]            i_action       = ACT_ENQ;
    logic signed [DATA_W-1:0]    i_value        = '0;
    logic [PRIO_W-1:0]           i_priority_req = PRI_LOW;
    logic                        i_out_stall    = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [STAT_W-1:0]           o_status;
    logic signed [DATA_W-1:0]    o_removed_value;
    logic signed [DATA_W-1:0]    o_head_value;
    logic [TOTAL_W-1:0]          o_entry_total;
    logic                        o_is_empty;
    logic                        o_is_full;

    // predicted queue contents, head at slot 0
    logic signed [DATA_W-1:0]    shadow_data [QDEPTH];
    logic [PRIO_W-1:0]           shadow_prio [QDEPTH];
    int                          shadow_count = 0;

    queue_report_t               pending_reports[$];
    stim_row_t                   stim_table[$];
    int                          errors       = 0;
    int                          idle_cycles  = 0;
    bit                          calm         = 1'b0;  // no idling on either side while set

    sorted_priority_queue_core #(
        .DEPTH (QDEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_priority_req  (i_priority_req),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_entry_total   (o_entry_total),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // apply one action to the shadow queue and return what the block should report
    function automatic queue_report_t apply_action(logic [ACT_W-1:0] act,
                                                   logic signed [DATA_W-1:0] val,
                                                   logic [PRIO_W-1:0] pri);
        queue_report_t rep;
        int            pos;
        rep = '0;
        rep.status = ST_DONE;
        if (act == ACT_ENQ) begin
            if (shadow_count >= QDEPTH) begin
                rep.status = ST_FULL;
            end else begin
                // walk past every entry of equal or higher rank, keeps fifo order
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= pri)
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_data[k] = shadow_data[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_data[pos] = val;
                shadow_prio[pos] = pri;
                shadow_count++;
            end
        end else if (act == ACT_DEQ) begin
            if (shadow_count == 0) begin
                rep.status = ST_EMPTY;
            end else begin
                rep.removed = shadow_data[0];
                for (int k = 0; k + 1 < shadow_count; k++) begin
                    shadow_data[k] = shadow_data[k+1];
                    shadow_prio[k] = shadow_prio[k+1];
                end
                shadow_count--;
            end
        end else if (act == ACT_CLR) begin
            shadow_count = 0;
        end
        // unused action code falls through with state untouched
        rep.head  = (shadow_count > 0) ? shadow_data[0] : '0;
        rep.total = shadow_count[TOTAL_W-1:0];
        rep.empty = (shadow_count == 0);
        rep.full  = (shadow_count >= QDEPTH);
        return rep;
    endfunction

    function automatic void compare_field(string name, longint got, longint want);
        if (got != want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic add_row(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                           logic [PRIO_W-1:0] pri, bit typed, queue_report_t want);
        stim_row_t row;
        row.action = act;
        row.value  = val;
        row.prio   = pri;
        row.typed  = typed;
        row.want   = want;
        stim_table.push_back(row);
    endtask

    // called just after a rising edge; returns just after the edge that took the item
    task automatic send_item(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                             logic [PRIO_W-1:0] pri, bit typed, queue_report_t want);
        queue_report_t predicted;
        // random gaps; valid is only lowered in a step where it is not raised
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_value        <= val;
        i_priority_req <= pri;
        // o_in_stall read here is the value before the edge settles
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_action(act, val, pri);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    // hold the sender off until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // result side: random stall, checking against the oldest expectation, watchdog
    always @(posedge i_clk) begin
        queue_report_t want;
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual status %0d",
                         $time, o_status);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("status",  o_status,                  want.status);
                compare_field("removed", longint'(o_removed_value), longint'(want.removed));
                compare_field("head",    longint'(o_head_value),    longint'(want.head));
                compare_field("total",   o_entry_total,             want.total);
                compare_field("empty",   o_is_empty,                want.empty);
                compare_field("full",    o_is_full,                 want.full);
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int                       mode;
        int                       roll;
        int                       enq_pct;
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty after reset, fill to full across all priorities,
        // full rejection, unused action, drain in rank order, clear
        add_row(ACT_DEQ, 32'sd1,  PRI_HIGH, 1'b1, REP_EMPTY_REJECT);
        add_row(ACT_ENQ, VAL_MAX, PRI_LOW,  1'b1,
                queue_report_t'{ST_DONE, 32'sd0, VAL_MAX, 4'd1, 1'b0, 1'b0});
        add_row(ACT_ENQ, VAL_MIN, PRI_HIGH, 1'b1,
                queue_report_t'{ST_DONE, 32'sd0, VAL_MIN, 4'd2, 1'b0, 1'b0});
        add_row(ACT_ENQ, 32'sd5,  PRI_MED,  1'b0, '0);
        add_row(ACT_ENQ, 32'sd6,  PRI_MED,  1'b0, '0);   // same rank, goes behind 5
        add_row(ACT_ENQ, 32'sd7,  PRI_TOP,  1'b0, '0);   // top code jumps ahead of high
        add_row(ACT_ENQ, 32'sd8,  PRI_HIGH, 1'b0, '0);
        add_row(ACT_ENQ, -32'sd9, PRI_LOW,  1'b0, '0);
        add_row(ACT_ENQ, 32'sd10, PRI_TOP,  1'b0, '0);   // eighth entry, now full
        add_row(ACT_ENQ, 32'sd11, PRI_TOP,  1'b1,
                queue_report_t'{ST_FULL, 32'sd0, 32'sd7, 4'd8, 1'b0, 1'b1});
        add_row(ACT_NOP, 32'sd12, PRI_LOW,  1'b0, '0);
        repeat (8)
            add_row(ACT_DEQ, 32'sd0, PRI_LOW, 1'b0, '0);
        add_row(ACT_DEQ, -32'sd1, PRI_TOP,  1'b1, REP_EMPTY_REJECT);
        add_row(ACT_ENQ, 32'sd0,  PRI_HIGH, 1'b0, '0);
        add_row(ACT_ENQ, -32'sd1, PRI_MED,  1'b0, '0);
        add_row(ACT_CLR, 32'sd3,  PRI_MED,  1'b1, REP_CLEARED);
        add_row(ACT_DEQ, 32'sd0,  PRI_LOW,  1'b1, REP_EMPTY_REJECT);
        add_row(ACT_CLR, 32'sd0,  PRI_LOW,  1'b1, REP_CLEARED);

        foreach (stim_table[i])
            send_item(stim_table[i].action, stim_table[i].value, stim_table[i].prio,
                      stim_table[i].typed, stim_table[i].want);

        drain_results();

        // random: stretches biased to fill, to drain, or mixed, so full and
        // empty are both hit often with random content in between
        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                mode = $urandom_range(2);
            if (n == 300)
                drain_results();
            calm = (n >= 400 && n < 480);
            enq_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            roll = $urandom_range(99);
            if (roll < enq_pct)
                act = ACT_ENQ;
            else if (roll < 95)
                act = ACT_DEQ;
            else if (roll < 97)
                act = ACT_CLR;
            else
                act = ACT_NOP;
            case ($urandom_range(9))
                0: val = VAL_MAX;
                1: val = VAL_MIN;
                2: val = '0;
                3: val = -32'sd1;
                default: val = $urandom;
            endcase
            send_item(act, val, PRIO_W'($urandom_range(3)), 1'b0, '0);
        end
        calm = 1'b0;

        drain_results();
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue_core.sv
bench/sorted_priority_queue_core_test.sv
